@@ rtl/core/uver_pkg.sv @@
// ----------------------------------------------------------------------------
// uver_pkg: shared types and constants
// Fixed-point formats, register indexes, rebuild sequencer states and the
// CORDIC arctangent table of the unit vector Euler rotation block.
// ----------------------------------------------------------------------------
package uver_pkg;

	// field and datapath widths
	localparam int unsigned IN_W     = 24;
	localparam int unsigned OUT_W    = 16;
	localparam int unsigned ANG_W    = 16;
	localparam int unsigned ENT_W    = 18;
	localparam int unsigned CORD_W   = 19;
	localparam int unsigned ZW       = 20;
	localparam int unsigned SUM_W    = 48;
	localparam int unsigned RAD_W    = 62;
	localparam int unsigned ROOT_W   = 31;
	localparam int unsigned NUM_W    = 48;
	localparam int unsigned QW       = 17;
	localparam int unsigned KW       = 5;
	localparam int unsigned SQRT_STEPS = 31;
	localparam int unsigned DIV_STEPS  = 17;

	// register indexes
	localparam logic [1:0] REG_YAW   = 2'd0;
	localparam logic [1:0] REG_PITCH = 2'd1;
	localparam logic [1:0] REG_ROLL  = 2'd2;

	// angle and scale constants, Q.16
	localparam logic signed [ZW-1:0]     ANG_HALF_PI = 20'sd102944;
	localparam logic signed [ZW-1:0]     ANG_PI      = 20'sd205887;
	localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 19'sd39797;
	localparam logic signed [ENT_W-1:0]  ONE_Q16     = 18'sd65536;
	localparam logic signed [ENT_W-1:0]  ENT_MAX     = 18'sd131071;
	localparam logic signed [ENT_W-1:0]  ENT_MIN     = {1'b1, 17'd0};
	localparam logic [QW-1:0]            Q_ONE       = 17'd65536;

	typedef enum logic [2:0] {
		RB_IDLE,
		RB_LOAD,
		RB_CORDIC,
		RB_FINISH,
		RB_MUL
	} rb_state_t;

	typedef logic signed [ENT_W-1:0] ent_t;
	typedef ent_t [8:0] mat_t;

	// per-item data that rides along the norm pipeline
	typedef struct packed {
		logic [2:0][IN_W-1:0] mag;
		logic [2:0]           neg;
		logic [KW-1:0]        k;
		logic                 zero;
	} side_t;

	// arctangent of 2^-i in Q.16
	function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] i);
		logic signed [ZW-1:0] a;
		case (i)
			4'd0:    a = 20'sd51472;
			4'd1:    a = 20'sd30386;
			4'd2:    a = 20'sd16055;
			4'd3:    a = 20'sd8150;
			4'd4:    a = 20'sd4091;
			4'd5:    a = 20'sd2047;
			4'd6:    a = 20'sd1024;
			4'd7:    a = 20'sd512;
			4'd8:    a = 20'sd256;
			4'd9:    a = 20'sd128;
			4'd10:   a = 20'sd64;
			4'd11:   a = 20'sd32;
			4'd12:   a = 20'sd16;
			4'd13:   a = 20'sd8;
			4'd14:   a = 20'sd4;
			default: a = 20'sd2;
		endcase
		return a;
	endfunction

endpackage

@@ rtl/core/uver_rot.sv @@
// ----------------------------------------------------------------------------
// uver_rot: rotation matrix cache
// Holds the three angle registers; on a write (and after reset) runs three
// CORDIC lanes for 16 steps, then builds Rz * (Rx * Ry) one entry at a time
// with three shared multipliers.
// ----------------------------------------------------------------------------
module uver_rot (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output logic              busy,
	output uver_pkg::mat_t    mat
);

	uver_pkg::rb_state_t state_q, state_nxt;

	logic signed [uver_pkg::ANG_W-1:0]  ang_q   [3];
	logic [3:0]                         step_q;
	logic signed [uver_pkg::CORD_W-1:0] x_q     [3];
	logic signed [uver_pkg::CORD_W-1:0] y_q     [3];
	logic signed [uver_pkg::ZW-1:0]     z_q     [3];
	logic                               flip_q  [3];
	uver_pkg::ent_t                     s_q     [3];
	uver_pkg::ent_t                     c_q     [3];
	logic [1:0]                         row_q, col_q;
	logic                               pass_q, phase_q;
	logic signed [2*uver_pkg::ENT_W-1:0] prod_q [3];
	uver_pkg::ent_t                     p_q     [9];
	uver_pkg::ent_t                     mat_q   [9];

	logic                               cfg_hit;
	logic signed [uver_pkg::ZW-1:0]     z_ld    [3];
	logic                               flip_ld [3];
	logic signed [uver_pkg::CORD_W-1:0] x_nx    [3];
	logic signed [uver_pkg::CORD_W-1:0] y_nx    [3];
	logic signed [uver_pkg::ZW-1:0]     z_nx    [3];
	uver_pkg::ent_t                     s_fin   [3];
	uver_pkg::ent_t                     c_fin   [3];
	uver_pkg::ent_t                     rx [9], ry [9], rz [9], am [9], bm [9];
	uver_pkg::ent_t                     a_op [3], b_op [3];
	logic [3:0]                         base, widx;
	uver_pkg::ent_t                     ent_res;

	assign cfg_hit = cfg_we && (cfg_index == uver_pkg::REG_YAW ||
		cfg_index == uver_pkg::REG_PITCH || cfg_index == uver_pkg::REG_ROLL);

	// angle registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) ang_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				uver_pkg::REG_YAW:   ang_q[0] <= cfg_data;
				uver_pkg::REG_PITCH: ang_q[1] <= cfg_data;
				uver_pkg::REG_ROLL:  ang_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= uver_pkg::RB_LOAD;
		else         state_q <= state_nxt;
	end

	// an angle write restarts the rebuild from any state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			uver_pkg::RB_IDLE:   if (cfg_hit) state_nxt = uver_pkg::RB_LOAD;
			uver_pkg::RB_LOAD:   state_nxt = uver_pkg::RB_CORDIC;
			uver_pkg::RB_CORDIC: if (step_q == 4'd15) state_nxt = uver_pkg::RB_FINISH;
			uver_pkg::RB_FINISH: state_nxt = uver_pkg::RB_MUL;
			uver_pkg::RB_MUL: begin
				if (phase_q && pass_q && row_q == 2'd2 && col_q == 2'd2)
					state_nxt = uver_pkg::RB_IDLE;
			end
			default: state_nxt = uver_pkg::RB_IDLE;
		endcase
		if (cfg_hit) state_nxt = uver_pkg::RB_LOAD;
	end

	always_comb begin
		busy = (state_q != uver_pkg::RB_IDLE);
	end

	// angle reduction to +-pi/2 and one cordic rotation step per lane
	always_comb begin
		logic signed [uver_pkg::ZW-1:0]     z0;
		logic signed [uver_pkg::CORD_W-1:0] xs, ys, cx, cy;
		for (int i = 0; i < 3; i++) begin
			z0 = $signed({ang_q[i][15], ang_q[i], 3'b000});
			if (z0 > uver_pkg::ANG_HALF_PI) begin
				z_ld[i] = z0 - uver_pkg::ANG_PI;
				flip_ld[i] = 1'b1;
			end else if (z0 < -uver_pkg::ANG_HALF_PI) begin
				z_ld[i] = z0 + uver_pkg::ANG_PI;
				flip_ld[i] = 1'b1;
			end else begin
				z_ld[i] = z0;
				flip_ld[i] = 1'b0;
			end
			xs = x_q[i] >>> step_q;
			ys = y_q[i] >>> step_q;
			if (z_q[i] >= 0) begin
				x_nx[i] = x_q[i] - ys;
				y_nx[i] = y_q[i] + xs;
				z_nx[i] = z_q[i] - uver_pkg::atan_q16(step_q);
			end else begin
				x_nx[i] = x_q[i] + ys;
				y_nx[i] = y_q[i] - xs;
				z_nx[i] = z_q[i] + uver_pkg::atan_q16(step_q);
			end
			cx = flip_q[i] ? -x_q[i] : x_q[i];
			cy = flip_q[i] ? -y_q[i] : y_q[i];
			if (cx > 19'sd65536)       c_fin[i] = uver_pkg::ONE_Q16;
			else if (cx < -19'sd65536) c_fin[i] = -uver_pkg::ONE_Q16;
			else                       c_fin[i] = cx[uver_pkg::ENT_W-1:0];
			if (cy > 19'sd65536)       s_fin[i] = uver_pkg::ONE_Q16;
			else if (cy < -19'sd65536) s_fin[i] = -uver_pkg::ONE_Q16;
			else                       s_fin[i] = cy[uver_pkg::ENT_W-1:0];
		end
	end

	// elementary matrices: lane 0 yaw, 1 pitch, 2 roll
	always_comb begin
		ry[0] = c_q[0];   ry[1] = '0; ry[2] = s_q[0];
		ry[3] = '0;       ry[4] = uver_pkg::ONE_Q16; ry[5] = '0;
		ry[6] = -s_q[0];  ry[7] = '0; ry[8] = c_q[0];
		rx[0] = uver_pkg::ONE_Q16; rx[1] = '0; rx[2] = '0;
		rx[3] = '0; rx[4] = c_q[1]; rx[5] = -s_q[1];
		rx[6] = '0; rx[7] = s_q[1]; rx[8] = c_q[1];
		rz[0] = c_q[2]; rz[1] = -s_q[2]; rz[2] = '0;
		rz[3] = s_q[2]; rz[4] = c_q[2];  rz[5] = '0;
		rz[6] = '0;     rz[7] = '0;      rz[8] = uver_pkg::ONE_Q16;
		for (int i = 0; i < 9; i++) begin
			am[i] = pass_q ? rz[i] : rx[i];
			bm[i] = pass_q ? p_q[i] : ry[i];
		end
	end

	// operand select and rounding of one matrix entry
	always_comb begin
		logic signed [37:0] acc;
		logic signed [37:0] sh;
		base = {2'b00, row_q} + {1'b0, row_q, 1'b0};
		widx = base + {2'b00, col_q};
		for (int k = 0; k < 3; k++) begin
			a_op[k] = am[base + 4'(k)];
			b_op[k] = bm[{2'b00, col_q} + 4'(3 * k)];
		end
		acc = 38'(prod_q[0]) + 38'(prod_q[1]) + 38'(prod_q[2]) + 38'sd32768;
		sh = acc >>> 16;
		if (sh > 38'(uver_pkg::ENT_MAX))      ent_res = uver_pkg::ENT_MAX;
		else if (sh < 38'(uver_pkg::ENT_MIN)) ent_res = uver_pkg::ENT_MIN;
		else                                   ent_res = sh[uver_pkg::ENT_W-1:0];
	end

	// sequencer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			row_q   <= '0;
			col_q   <= '0;
			pass_q  <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			case (state_q)
				uver_pkg::RB_LOAD:   step_q <= '0;
				uver_pkg::RB_CORDIC: step_q <= step_q + 4'd1;
				uver_pkg::RB_FINISH: begin
					row_q   <= '0;
					col_q   <= '0;
					pass_q  <= 1'b0;
					phase_q <= 1'b0;
				end
				uver_pkg::RB_MUL: begin
					phase_q <= ~phase_q;
					if (phase_q) begin
						if (col_q == 2'd2) begin
							col_q <= '0;
							if (row_q == 2'd2) begin
								row_q  <= '0;
								pass_q <= 1'b1;
							end else begin
								row_q <= row_q + 2'd1;
							end
						end else begin
							col_q <= col_q + 2'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// cordic lanes and matrix storage
	always_ff @(posedge clk) begin
		case (state_q)
			uver_pkg::RB_LOAD: begin
				for (int i = 0; i < 3; i++) begin
					x_q[i]    <= uver_pkg::CORDIC_GAIN;
					y_q[i]    <= '0;
					z_q[i]    <= z_ld[i];
					flip_q[i] <= flip_ld[i];
				end
			end
			uver_pkg::RB_CORDIC: begin
				for (int i = 0; i < 3; i++) begin
					x_q[i] <= x_nx[i];
					y_q[i] <= y_nx[i];
					z_q[i] <= z_nx[i];
				end
			end
			uver_pkg::RB_FINISH: begin
				for (int i = 0; i < 3; i++) begin
					s_q[i] <= s_fin[i];
					c_q[i] <= c_fin[i];
				end
			end
			uver_pkg::RB_MUL: begin
				if (!phase_q) begin
					for (int k = 0; k < 3; k++) prod_q[k] <= a_op[k] * b_op[k];
				end else if (pass_q) begin
					mat_q[widx] <= ent_res;
				end else begin
					p_q[widx] <= ent_res;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int i = 0; i < 9; i++) mat[i] = mat_q[i];
	end

endmodule

@@ rtl/core/uver_sqrt.sv @@
// ----------------------------------------------------------------------------
// uver_sqrt: pipelined integer square root
// Restoring square root of a 62-bit radicand, one result bit per stage,
// 32 register stages in all; per-item side data travels alongside.
// ----------------------------------------------------------------------------
module uver_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  logic [uver_pkg::RAD_W-1:0]    n_in,
	input  uver_pkg::side_t               side_in,
	output logic                          vld_out,
	output logic [uver_pkg::ROOT_W-1:0]   root,
	output uver_pkg::side_t               side_out
);

	localparam int unsigned N = uver_pkg::SQRT_STEPS;

	logic [uver_pkg::RAD_W-1:0] n_s   [N+1];
	logic [uver_pkg::RAD_W-1:0] res_s [N+1];
	uver_pkg::side_t            side_s [N+1];
	logic [N:0]                 v_s;
	logic [uver_pkg::RAD_W-1:0] n_n   [N];
	logic [uver_pkg::RAD_W-1:0] res_n [N];

	// one trial subtract per stage, stage i decides bit N-1-i
	always_comb begin
		logic [uver_pkg::RAD_W-1:0] bval;
		logic [uver_pkg::RAD_W-1:0] t;
		for (int i = 0; i < N; i++) begin
			bval = 62'(1) << (2 * (N - 1 - i));
			t = res_s[i] + bval;
			if (n_s[i] >= t) begin
				n_n[i]   = n_s[i] - t;
				res_n[i] = (res_s[i] >> 1) + bval;
			end else begin
				n_n[i]   = n_s[i];
				res_n[i] = res_s[i] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0]    <= n_in;
			res_s[0]  <= '0;
			side_s[0] <= side_in;
			for (int i = 0; i < N; i++) begin
				n_s[i+1]    <= n_n[i];
				res_s[i+1]  <= res_n[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)  v_s <= '0;
		else if (en)  v_s <= {v_s[N-1:0], vld_in};
	end

	assign vld_out  = v_s[N];
	assign root     = res_s[N][uver_pkg::ROOT_W-1:0];
	assign side_out = side_s[N];

endmodule

@@ rtl/core/uver_div.sv @@
// ----------------------------------------------------------------------------
// uver_div: pipelined normalizing divider
// Three lanes compute round(|v| * 2^(k+16) / r), one quotient bit per stage,
// then clamp to one and apply the sign; 19 register stages.
// ----------------------------------------------------------------------------
module uver_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  logic [uver_pkg::ROOT_W-1:0]   root,
	input  uver_pkg::side_t               side_in,
	output logic                          vld_out,
	output uver_pkg::ent_t                u [3],
	output logic                          zero_out
);

	localparam int unsigned N = uver_pkg::DIV_STEPS;

	logic [uver_pkg::NUM_W-1:0]  rem_s [N+1][3];
	logic [uver_pkg::QW-1:0]     q_s   [N+1][3];
	logic [uver_pkg::ROOT_W-1:0] r_s   [N+1];
	logic [2:0]                  neg_s [N+1];
	logic                        zero_s [N+1];
	logic [N+1:0]                v_s;
	uver_pkg::ent_t              u_s   [3];
	logic                        zero_sf;

	logic [uver_pkg::NUM_W-1:0]  num   [3];
	logic [uver_pkg::NUM_W-1:0]  rem_n [N][3];
	logic [uver_pkg::QW-1:0]     q_n   [N][3];
	uver_pkg::ent_t              u_n   [3];

	// numerator with half the divisor added for rounding
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			num[l] = (48'({side_in.mag[l], 16'd0}) << side_in.k)
				+ 48'(root[uver_pkg::ROOT_W-1:1]);
		end
	end

	// restoring division steps, stage j decides quotient bit N-1-j
	always_comb begin
		logic [uver_pkg::NUM_W-1:0] d;
		for (int j = 0; j < N; j++) begin
			d = 48'(r_s[j]) << (N - 1 - j);
			for (int l = 0; l < 3; l++) begin
				if (rem_s[j][l] >= d) begin
					rem_n[j][l] = rem_s[j][l] - d;
					q_n[j][l]   = q_s[j][l] | (17'(1) << (N - 1 - j));
				end else begin
					rem_n[j][l] = rem_s[j][l];
					q_n[j][l]   = q_s[j][l];
				end
			end
		end
	end

	// clamp and sign
	always_comb begin
		logic [uver_pkg::QW-1:0] qc;
		for (int l = 0; l < 3; l++) begin
			qc = (q_s[N][l] > uver_pkg::Q_ONE) ? uver_pkg::Q_ONE : q_s[N][l];
			u_n[l] = neg_s[N][l] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				rem_s[0][l] <= num[l];
				q_s[0][l]   <= '0;
			end
			r_s[0]    <= root;
			neg_s[0]  <= side_in.neg;
			zero_s[0] <= side_in.zero;
			for (int j = 0; j < N; j++) begin
				for (int l = 0; l < 3; l++) begin
					rem_s[j+1][l] <= rem_n[j][l];
					q_s[j+1][l]   <= q_n[j][l];
				end
				r_s[j+1]    <= r_s[j];
				neg_s[j+1]  <= neg_s[j];
				zero_s[j+1] <= zero_s[j];
			end
			for (int l = 0; l < 3; l++) u_s[l] <= u_n[l];
			zero_sf <= zero_s[N];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)  v_s <= '0;
		else if (en)  v_s <= {v_s[N:0], vld_in};
	end

	assign vld_out  = v_s[N+1];
	assign zero_out = zero_sf;
	always_comb begin
		for (int l = 0; l < 3; l++) u[l] = u_s[l];
	end

endmodule

@@ rtl/core/unit_vector_euler_rotation.sv @@
// ----------------------------------------------------------------------------
// unit_vector_euler_rotation: normalize a 3D vector and rotate it
// Scales the input vector to unit length and applies the cached Euler
// rotation matrix Rz(roll) * Rx(pitch) * Ry(yaw), giving Q1.14 components.
// ----------------------------------------------------------------------------
// One item is accepted every clock cycle while s_tready is high; most of
// the pipeline depth lies in the 31-stage square root (one root bit per
// stage) and the 17-stage divider (one quotient bit per stage) of the norm
// path. The whole pipeline advances whenever the output register is empty
// or being taken. After reset and after each write of an angle register the
// matrix is rebuilt (16 CORDIC steps, then 18 entries), and s_tready stays
// low until the rebuild is done; a zero vector gives zero components with
// zero_length set.
module unit_vector_euler_rotation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // x_in[23:0], y_in[47:24], z_in[71:48]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // x_out[15:0], y_out[31:16], z_out[47:32]
	output logic [0:0]  m_tuser    // zero_length[0]
);

	logic           en;
	logic           busy;
	uver_pkg::mat_t mat;

	logic signed [uver_pkg::IN_W-1:0] vin  [3];
	logic signed [47:0]               sqv  [3];

	logic                              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [46:0]                       sq_s1  [3];
	logic [uver_pkg::IN_W-1:0]         mag_s1 [3];
	logic [2:0]                        neg_s1;
	logic [uver_pkg::SUM_W-1:0]        sum_s2;
	logic [uver_pkg::IN_W-1:0]         mag_s2 [3];
	logic [2:0]                        neg_s2;
	logic [uver_pkg::SUM_W-1:0]        sum_s3;
	uver_pkg::side_t                   side_s3;
	logic [uver_pkg::KW-1:0]           k_c;
	logic [uver_pkg::RAD_W-1:0]        rad_c;

	logic                              sq_vld;
	logic [uver_pkg::ROOT_W-1:0]       root;
	uver_pkg::side_t                   sq_side;
	logic                              dv_vld;
	uver_pkg::ent_t                    u [3];
	logic                              dv_zero;

	logic signed [35:0]                prod_s4 [3][3];
	logic                              zero_s4;
	logic signed [uver_pkg::OUT_W-1:0] o_s5    [3];
	logic signed [uver_pkg::OUT_W-1:0] o_c     [3];
	logic                              zero_s5;

	// pipeline advance and input handshake
	assign en       = !v_s5 || m_tready;
	assign s_tready = en && !busy && !cfg_we;

	uver_rot u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.mat       (mat)
	);

	// stage 1: squares and magnitudes
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			vin[l] = $signed(s_tdata[uver_pkg::IN_W*l +: uver_pkg::IN_W]);
			sqv[l] = vin[l] * vin[l];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				sq_s1[l]  <= sqv[l][46:0];
				mag_s1[l] <= vin[l][23] ? 24'(-vin[l]) : 24'(vin[l]);
				neg_s1[l] <= vin[l][23];
			end
		end
	end

	// stage 2: sum of squares
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= 48'(sq_s1[0]) + 48'(sq_s1[1]) + 48'(sq_s1[2]);
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
		end
	end

	// stage 3: bit length of the sum, byte then bit
	always_comb begin
		logic [2:0] hg;
		logic [2:0] hb;
		logic [7:0] byt;
		logic [5:0] bl;
		logic [5:0] kd;
		hg = '0;
		for (int g = 0; g < 6; g++) begin
			if (|sum_s2[8*g +: 8]) hg = 3'(g);
		end
		byt = sum_s2[{hg, 3'b000} +: 8];
		hb = '0;
		for (int b = 0; b < 8; b++) begin
			if (byt[b]) hb = 3'(b);
		end
		bl  = {hg, hb} + 6'd1;
		kd  = 6'd62 - bl;
		k_c = kd[5:1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3       <= sum_s2;
			side_s3.k    <= k_c;
			side_s3.zero <= (sum_s2 == '0);
			side_s3.neg  <= neg_s2;
			for (int l = 0; l < 3; l++) side_s3.mag[l] <= mag_s2[l];
		end
	end

	// radicand scaled so its bit length is 61 or 62
	assign rad_c = 62'(sum_s3) << {side_s3.k, 1'b0};

	uver_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (v_s3),
		.n_in     (rad_c),
		.side_in  (side_s3),
		.vld_out  (sq_vld),
		.root     (root),
		.side_out (sq_side)
	);

	uver_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (sq_vld),
		.root     (root),
		.side_in  (sq_side),
		.vld_out  (dv_vld),
		.u        (u),
		.zero_out (dv_zero)
	);

	// stage 4: matrix times unit vector products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				for (int l = 0; l < 3; l++) begin
					prod_s4[j][l] <= $signed(mat[3*j+l]) * u[l];
				end
			end
			zero_s4 <= dv_zero;
		end
	end

	// stage 5: row sums, round to Q1.14 and clamp
	always_comb begin
		logic signed [37:0] acc;
		logic signed [37:0] sh;
		for (int j = 0; j < 3; j++) begin
			acc = 38'(prod_s4[j][0]) + 38'(prod_s4[j][1]) + 38'(prod_s4[j][2])
				+ 38'sd131072;
			sh = acc >>> 18;
			if (zero_s4)               o_c[j] = '0;
			else if (sh > 38'sd16384)  o_c[j] = 16'sd16384;
			else if (sh < -38'sd16384) o_c[j] = -16'sd16384;
			else                       o_c[j] = sh[uver_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) o_s5[j] <= o_c[j];
			zero_s5 <= zero_s4;
		end
	end

	// valid bits of the top-level stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid && s_tready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= dv_vld;
			v_s5 <= v_s4;
		end
	end

	assign m_tvalid   = v_s5;
	assign m_tdata    = {o_s5[2], o_s5[1], o_s5[0]};
	assign m_tuser[0] = zero_s5;

endmodule

@@ rtl/core/uver_chk.sv @@
// ----------------------------------------------------------------------------
// uver_chk: port-level checker
// Watches the ports of the rotation block for stall, rebuild and zero-vector
// behavior; bound to the top level below.
// ----------------------------------------------------------------------------
module uver_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [1:0]  cfg_index,
	input logic [15:0] cfg_data,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [71:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// zero vector gives zero components
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 48'd0)
		else $error("zero vector result not zero");

	// an angle write starts a rebuild that blocks input
	a_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == uver_pkg::REG_YAW || cfg_index == uver_pkg::REG_PITCH ||
		cfg_index == uver_pkg::REG_ROLL) |=> !s_tready)
		else $error("input accepted during matrix rebuild");

	// input is taken only while the pipeline advances
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid || m_tready)
		else $error("input ready while output stalled");

endmodule

bind unit_vector_euler_rotation uver_chk u_chk (.*);
